// ===== sv/pfl_pkg.sv =====
// Shared types and constants for the PI force loop with quintic ramp.
// Used by pfl_div, pfl_mul and pi_force_loop_quintic_ref.
`default_nettype none
package pfl_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// shared multiplier operand width (signed)
	localparam int MW = 36;
	localparam int PW = 2 * MW;

	// shared divider widths
	localparam int DQW = 41;
	localparam int DVW = 24;
	localparam int DCW = 6;

	localparam int S_ITERS = 30;
	// folds of the P magnitude by 255 before the last correction
	localparam int P_FOLDS = 6;

	localparam logic signed [39:0] I32_MAX = 40'sd2147483647;
	localparam logic signed [39:0] I32_MIN = -40'sd2147483648;
	localparam logic signed [49:0] I48_MAX = (50'sd1 <<< 47) - 50'sd1;
	localparam logic signed [49:0] I48_MIN = -(50'sd1 <<< 47);

	localparam int DRIVE_LIMIT_INT = 70;

	localparam logic [1:0] SAT_NONE = 2'd0;
	localparam logic [1:0] SAT_HIGH = 2'd1;
	localparam logic [1:0] SAT_LOW  = 2'd2;

	localparam logic [2:0] REG_RAMP   = 3'd0;
	localparam logic [2:0] REG_TARGET = 3'd1;
	localparam logic [2:0] REG_PSCALE = 3'd2;
	localparam logic [2:0] REG_IGAIN  = 3'd3;
	localparam logic [2:0] REG_PERIOD = 3'd4;
	localparam logic [2:0] REG_AWEN   = 3'd5;

	localparam logic MODE_RESTART = 1'b0;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SDIV = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_WB   = 7'b0001000,
		ST_ERR  = 7'b0010000,
		ST_PDIV = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	typedef enum logic [3:0] {
		OP_S2, OP_S3, OP_S4, OP_S5, OP_REF, OP_INT, OP_P, OP_ILO, OP_IHI
	} op_t;

	typedef struct packed {
		logic           start;
		logic [DCW-1:0] iters;
	} div_req_t;

endpackage
`default_nettype wire

// ===== sv/pfl_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pfl_pkg.
`default_nettype none
module pfl_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire pfl_pkg::div_req_t        req,
	input  wire logic [pfl_pkg::DVW-1:0]  rem_init,
	input  wire logic [pfl_pkg::DQW-1:0]  dividend,
	input  wire logic [pfl_pkg::DVW-1:0]  divisor,
	output logic                          done,
	output logic [pfl_pkg::DQW-1:0]       quot
);
	logic [pfl_pkg::DVW-1:0] rem_q, dvs_q;
	logic [pfl_pkg::DQW-1:0] q_q;
	logic [pfl_pkg::DCW-1:0] cnt_q;
	logic                    active_q, done_q;
	logic [pfl_pkg::DVW:0]   r2, r2d;
	logic                    bit_ok;

	assign r2     = {rem_q, q_q[pfl_pkg::DQW-1]};
	assign r2d    = r2 - {1'b0, dvs_q};
	assign bit_ok = (r2 >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q    <= req.iters;
			end else if (active_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pfl_pkg::DCW'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= rem_init;
			q_q   <= dividend;
			dvs_q <= divisor;
		end else if (active_q) begin
			// shift in next dividend bit, subtract when it fits
			rem_q <= bit_ok ? r2d[pfl_pkg::DVW-1:0] : r2[pfl_pkg::DVW-1:0];
			q_q   <= {q_q[pfl_pkg::DQW-2:0], bit_ok};
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule
`default_nettype wire

// ===== sv/pfl_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on pfl_pkg.
`default_nettype none
module pfl_mul (
	input  wire logic                           clk,
	input  wire logic signed [pfl_pkg::MW-1:0]  a,
	input  wire logic signed [pfl_pkg::MW-1:0]  b,
	output logic signed [pfl_pkg::PW-1:0]       p
);
	logic signed [pfl_pkg::PW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;
endmodule
`default_nettype wire

// ===== sv/pi_force_loop_quintic_ref.sv =====
// PI force loop with quintic reference ramp, top level. Uses pfl_pkg, pfl_div, pfl_mul.
// A restart beat is taken in idle and gives no result. A tick beat inside the ramp runs a
// 30-step ramp division, six folds for the division by 255 and nine passes through the
// shared multiplier; once the ramp is over, the division and the ramp passes are skipped.
// Beats are taken only in idle, once the output register has taken the last result.
// Reset (arst_n low): registers to their documented defaults, integral and levels to zero.
`default_nettype none
module pi_force_loop_quintic_ref #(
	parameter int FRAC_BITS = pfl_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [31:0] elapsed_ticks, [63:32] measured
	input  wire logic        s_tuser,   // [0] mode
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // [31:0] reference, [55:32] drive
	output logic [1:0]       m_tuser,   // [1:0] saturated
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [23:0] cfg_wdata
);
	localparam logic signed [49:0] LIMIT = 50'(pfl_pkg::DRIVE_LIMIT_INT) <<< FRAC_BITS;

	// configuration registers
	logic [23:0] ramp_q;
	logic [9:0]  target_q;
	logic [7:0]  pscale_q;
	logic [15:0] igain_q;
	logic [15:0] period_q;
	logic        aw_q;

	// loop state
	logic signed [31:0] ref_q, start_q, meas_q;
	logic signed [47:0] integ_q;
	logic               ien_q;

	// working registers
	pfl_pkg::state_t    state_q;
	pfl_pkg::op_t       op_q;
	logic [29:0]        s3_q, s4_q;
	logic signed [32:0] err_q;
	logic signed [41:0] p_q, acc_q;
	logic               pneg_q;
	logic signed [49:0] drv_q;
	logic signed [pfl_pkg::MW-1:0] ma_q, mb_q;
	logic [40:0]        fy_q, fq_q;
	logic [2:0]         fcnt_q;

	// output register
	logic               ovalid_q;
	logic [31:0]        oref_q;
	logic [23:0]        odrv_q;
	logic [1:0]         osat_q;

	// shared units
	pfl_pkg::div_req_t           dreq;
	logic [pfl_pkg::DVW-1:0]     d_rem, d_dvs;
	logic [pfl_pkg::DQW-1:0]     d_dvd, d_quot;
	logic                        d_done;
	logic signed [pfl_pkg::PW-1:0] prod;

	pfl_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .rem_init(d_rem),
		.dividend(d_dvd), .divisor(d_dvs), .done(d_done), .quot(d_quot)
	);

	pfl_mul u_mul (.clk(clk), .a(ma_q), .b(mb_q), .p(prod));

	logic in_acc;
	assign s_tready = (state_q == pfl_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// goal level and its 32-bit saturated form
	logic signed [39:0] goal, goal32;
	assign goal   = 40'(target_q) <<< FRAC_BITS;
	assign goal32 = (goal > pfl_pkg::I32_MAX) ? pfl_pkg::I32_MAX : goal;

	logic ramp_over;
	assign ramp_over = (s_tdata[31:0] >= {8'd0, ramp_q});

	// divider request: ramp fraction from idle
	always_comb begin
		dreq  = '0;
		d_rem = s_tdata[23:0];
		d_dvd = '0;
		d_dvs = ramp_q;
		if (in_acc && s_tuser != pfl_pkg::MODE_RESTART && !ramp_over) begin
			dreq.start = 1'b1;
			dreq.iters = pfl_pkg::DCW'(pfl_pkg::S_ITERS);
		end
	end

	// quotient by 255 once the folds are done; a remainder of exactly 255 adds one
	logic [40:0] pmag;
	assign pmag = fq_q + 41'(fy_q == 41'd255);

	// write-back arithmetic on the registered product
	logic [29:0]        pw;
	logic signed [39:0] poly_w, diff;
	logic [28:0]        poly_q4;
	logic signed [71:0] rsh;
	logic signed [39:0] val, val32;
	logic signed [49:0] step, isum, isat;
	logic signed [65:0] ifull;
	logic signed [49:0] iterm;

	always_comb begin
		pw     = prod[59:30];
		// blend polynomial 10 s^3 - 15 s^4 + 6 s^5, clamped to [0, 1] in Q0.30
		poly_w = 40'sd10 * $signed(40'(s3_q)) - 40'sd15 * $signed(40'(s4_q))
		       + 40'sd6 * $signed(40'(pw));
		if (poly_w < 0)
			poly_q4 = '0;
		else if (poly_w > (40'sd1 <<< 30))
			poly_q4 = 29'(1) << 28;
		else
			poly_q4 = poly_w[30:2];
		diff   = goal - 40'(start_q);
		rsh    = prod >>> 28;
		val    = 40'(start_q) + rsh[39:0];
		val32  = (val > pfl_pkg::I32_MAX) ? pfl_pkg::I32_MAX :
		         (val < pfl_pkg::I32_MIN) ? pfl_pkg::I32_MIN : val;
		step   = prod[57:8];
		isum   = 50'(integ_q) + step;
		isat   = (isum > pfl_pkg::I48_MAX) ? pfl_pkg::I48_MAX :
		         (isum < pfl_pkg::I48_MIN) ? pfl_pkg::I48_MIN : isum;
		ifull  = ($signed({prod[41:0], 24'd0})) + 66'(acc_q);
		iterm  = ifull[65:16];
	end

	// clamp and anti-windup decision
	logic [1:0]         sat;
	logic signed [49:0] dclamp;
	always_comb begin
		sat    = pfl_pkg::SAT_NONE;
		dclamp = drv_q;
		if (drv_q > LIMIT) begin
			sat    = pfl_pkg::SAT_HIGH;
			dclamp = LIMIT;
		end else if (drv_q < -LIMIT) begin
			sat    = pfl_pkg::SAT_LOW;
			dclamp = -LIMIT;
		end
	end

	// load the output register once the previous result beat has gone
	logic out_load;
	assign out_load = (state_q == pfl_pkg::ST_FIN) && (!ovalid_q || m_tready);

	// configuration writes; out-of-range index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q   <= 24'd1000;
			target_q <= '0;
			pscale_q <= 8'd1;
			igain_q  <= 16'd655;
			period_q <= 16'd256;
			aw_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				pfl_pkg::REG_RAMP:   ramp_q   <= cfg_wdata;
				pfl_pkg::REG_TARGET: target_q <= cfg_wdata[9:0];
				pfl_pkg::REG_PSCALE: pscale_q <= cfg_wdata[7:0];
				pfl_pkg::REG_IGAIN:  igain_q  <= cfg_wdata[15:0];
				pfl_pkg::REG_PERIOD: period_q <= cfg_wdata[15:0];
				pfl_pkg::REG_AWEN:   aw_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pfl_pkg::ST_IDLE;
			op_q     <= pfl_pkg::OP_S2;
			ref_q    <= '0;
			start_q  <= '0;
			integ_q  <= '0;
			ien_q    <= 1'b1;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && m_tready && !out_load)
				ovalid_q <= 1'b0;
			case (state_q)
				pfl_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == pfl_pkg::MODE_RESTART) begin
							// latch start level, clear integral
							start_q <= ref_q;
							integ_q <= '0;
						end else if (ramp_over) begin
							ref_q   <= goal32[31:0];
							state_q <= pfl_pkg::ST_ERR;
						end else begin
							state_q <= pfl_pkg::ST_SDIV;
						end
					end
				end
				pfl_pkg::ST_SDIV: begin
					if (d_done) begin
						ma_q    <= pfl_pkg::MW'(d_quot[29:0]);
						mb_q    <= pfl_pkg::MW'(d_quot[29:0]);
						op_q    <= pfl_pkg::OP_S2;
						state_q <= pfl_pkg::ST_MUL;
					end
				end
				pfl_pkg::ST_MUL: state_q <= pfl_pkg::ST_WB;
				pfl_pkg::ST_ERR: begin
					err_q   <= 33'(ref_q) - 33'(meas_q);
					ma_q    <= pfl_pkg::MW'(33'(ref_q) - 33'(meas_q));
					mb_q    <= pfl_pkg::MW'(period_q);
					op_q    <= pfl_pkg::OP_INT;
					state_q <= pfl_pkg::ST_MUL;
				end
				pfl_pkg::ST_WB: begin
					state_q <= pfl_pkg::ST_MUL;
					case (op_q)
						pfl_pkg::OP_S2: begin
							ma_q <= pfl_pkg::MW'(pw);
							op_q <= pfl_pkg::OP_S3;
						end
						pfl_pkg::OP_S3: begin
							s3_q <= pw;
							ma_q <= pfl_pkg::MW'(pw);
							op_q <= pfl_pkg::OP_S4;
						end
						pfl_pkg::OP_S4: begin
							s4_q <= pw;
							ma_q <= pfl_pkg::MW'(pw);
							op_q <= pfl_pkg::OP_S5;
						end
						pfl_pkg::OP_S5: begin
							ma_q <= pfl_pkg::MW'(diff);
							mb_q <= pfl_pkg::MW'(poly_q4);
							op_q <= pfl_pkg::OP_REF;
						end
						pfl_pkg::OP_REF: begin
							ref_q   <= val32[31:0];
							state_q <= pfl_pkg::ST_ERR;
						end
						pfl_pkg::OP_INT: begin
							if (ien_q)
								integ_q <= isat[47:0];
							ma_q <= pfl_pkg::MW'(err_q);
							mb_q <= pfl_pkg::MW'(pscale_q);
							op_q <= pfl_pkg::OP_P;
						end
						pfl_pkg::OP_P: begin
							// fold the magnitude: x = 256 q + r = 255 q + (q + r)
							pneg_q  <= prod[41];
							fy_q    <= prod[41] ? 41'(-prod[41:0]) : prod[40:0];
							fq_q    <= '0;
							fcnt_q  <= 3'(pfl_pkg::P_FOLDS);
							state_q <= pfl_pkg::ST_PDIV;
						end
						pfl_pkg::OP_ILO: begin
							acc_q <= prod[41:0];
							ma_q  <= pfl_pkg::MW'(igain_q);
							mb_q  <= pfl_pkg::MW'($signed(integ_q[47:24]));
							op_q  <= pfl_pkg::OP_IHI;
						end
						pfl_pkg::OP_IHI: begin
							drv_q   <= 50'(p_q) + iterm;
							state_q <= pfl_pkg::ST_FIN;
						end
						default: state_q <= pfl_pkg::ST_IDLE;
					endcase
				end
				pfl_pkg::ST_PDIV: begin
					if (fcnt_q != 3'd0) begin
						fq_q   <= fq_q + 41'(fy_q[40:8]);
						fy_q   <= 41'(fy_q[40:8]) + 41'(fy_q[7:0]);
						fcnt_q <= fcnt_q - 3'd1;
					end else begin
						// truncate toward zero: restore the sign of the magnitude quotient
						p_q     <= pneg_q ? -42'(pmag) : 42'(pmag);
						ma_q    <= pfl_pkg::MW'(igain_q);
						mb_q    <= pfl_pkg::MW'(integ_q[23:0]);
						op_q    <= pfl_pkg::OP_ILO;
						state_q <= pfl_pkg::ST_MUL;
					end
				end
				pfl_pkg::ST_FIN: begin
					// hold until the output register is free
					if (out_load) begin
						ovalid_q <= 1'b1;
						oref_q   <= ref_q;
						odrv_q   <= dclamp[23:0];
						osat_q   <= sat;
						ien_q    <= !(aw_q && ((sat == pfl_pkg::SAT_HIGH && err_q > 0) ||
						                       (sat == pfl_pkg::SAT_LOW && err_q < 0)));
						state_q  <= pfl_pkg::ST_IDLE;
					end
				end
				default: state_q <= pfl_pkg::ST_IDLE;
			endcase
		end
	end

	// capture measured level with the beat
	always_ff @(posedge clk) begin
		if (in_acc)
			meas_q <= s_tdata[63:32];
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {odrv_q, oref_q};
	assign m_tuser  = osat_q;

	// the divider only reports completion while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		d_done |-> (state_q == pfl_pkg::ST_SDIV || state_q == pfl_pkg::ST_PDIV))
		else $error("divider done outside a divide wait");

	// a high clamp always carries exactly the positive limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == pfl_pkg::SAT_HIGH) |-> (m_tdata[55:32] == LIMIT[23:0]))
		else $error("high clamp without limit drive");

	// no invalid saturation code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != 2'd3))
		else $error("bad saturation code");
endmodule
`default_nettype wire

// ===== tb/tb_pi_force_loop_quintic_ref.sv =====
// Self-checking testbench for pi_force_loop_quintic_ref: drives restart and tick beats,
// predicts reference, drive and saturation flag, and compares every result beat.
// Depends on pfl_pkg and the block's RTL only.
`timescale 1ns / 1ps
module tb_pi_force_loop_quintic_ref;

	localparam int  HALF_PERIOD  = 6;
	localparam int  RESET_CYCLES = 11;
	localparam int  NUM_ITEMS    = 1800;
	localparam int  CYCLE_LIMIT  = 2000000;
	localparam int  LONG_HOLD    = 3000;
	localparam int  DRAIN_CYCLES = 100;
	localparam logic MODE_TICK   = 1'b1;
	// indexes past the register map; writes there must be dropped
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic [31:0] level;
		logic [23:0] drive;
		logic [1:0]  sat;
	} loop_out_t;

	// Predicts the force loop and holds the results still owed by the block.
	class force_loop_board;
		longint ramp_ticks, target, pscale, igain, period, awen;
		longint cur_level, start_level, integ;
		bit integ_on;
		loop_out_t owed[$];
		int fails;

		function new();
			ramp_ticks = 1000; target = 0; pscale = 1; igain = 655;
			period = 256; awen = 1;
			cur_level = 0; start_level = 0; integ = 0; integ_on = 1;
			fails = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [23:0] val);
			case (idx)
				pfl_pkg::REG_RAMP:   ramp_ticks = longint'(val);
				pfl_pkg::REG_TARGET: target     = longint'(val[9:0]);
				pfl_pkg::REG_PSCALE: pscale     = longint'(val[7:0]);
				pfl_pkg::REG_IGAIN:  igain      = longint'(val[15:0]);
				pfl_pkg::REG_PERIOD: period     = longint'(val[15:0]);
				pfl_pkg::REG_AWEN:   awen       = longint'(val[0]);
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		// quintic ramp level for the given elapsed count
		function longint ramp_level(logic [31:0] el);
			longint goal, poly, diff;
			longint unsigned s, s2, s3, s4, s5;
			goal = target <<< 16;
			if (longint'(el) >= ramp_ticks)
				return clip(goal, pfl_pkg::I32_MIN, pfl_pkg::I32_MAX);
			s  = (longint'(el) << 30) / ramp_ticks;
			s2 = (s * s) >> 30;
			s3 = (s2 * s) >> 30;
			s4 = (s3 * s) >> 30;
			s5 = (s4 * s) >> 30;
			poly = 10 * longint'(s3) - 15 * longint'(s4) + 6 * longint'(s5);
			poly = clip(poly, 0, longint'(1) << 30) / 4;
			diff = goal - start_level;
			return clip(start_level + ((diff * poly) >>> 28),
			            pfl_pkg::I32_MIN, pfl_pkg::I32_MAX);
		endfunction

		function void note_beat(logic mode, logic [31:0] el, logic [31:0] meas);
			longint err, drv, lim;
			loop_out_t r;
			if (mode == pfl_pkg::MODE_RESTART) begin
				start_level = cur_level;
				integ = 0;
				return;
			end
			cur_level = ramp_level(el);
			err = cur_level - longint'(signed'(meas));
			if (integ_on)
				integ = clip(integ + ((err * period) >>> 8), pfl_pkg::I48_MIN, pfl_pkg::I48_MAX);
			drv = (err * pscale) / 255 + ((igain * integ) >>> 16);
			lim = longint'(pfl_pkg::DRIVE_LIMIT_INT) <<< 16;
			r.sat = pfl_pkg::SAT_NONE;
			if (drv > lim) begin
				drv = lim;
				r.sat = pfl_pkg::SAT_HIGH;
			end else if (drv < -lim) begin
				drv = -lim;
				r.sat = pfl_pkg::SAT_LOW;
			end
			integ_on = !(awen != 0 && ((r.sat == pfl_pkg::SAT_HIGH && err > 0) ||
			                           (r.sat == pfl_pkg::SAT_LOW && err < 0)));
			r.level = cur_level[31:0];
			r.drive = drv[23:0];
			owed.push_back(r);
		endfunction

		function void check_result(logic [31:0] level, logic [23:0] drive, logic [1:0] sat);
			loop_out_t e;
			if (owed.size() == 0) begin
				$error("unexpected result beat: reference %h drive %h", level, drive);
				fails++;
				return;
			end
			e = owed.pop_front();
			if (level !== e.level) begin
				$error("reference: expected %h, got %h", e.level, level);
				fails++;
			end
			if (drive !== e.drive) begin
				$error("drive: expected %h, got %h", e.drive, drive);
				fails++;
			end
			if (sat !== e.sat) begin
				$error("saturated: expected %0d, got %0d", e.sat, sat);
				fails++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // [31:0] elapsed_ticks, [63:32] measured
	logic        s_tuser = 1'b0; // [0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // [31:0] reference, [55:32] drive
	logic [1:0]  m_tuser;        // [1:0] saturated
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [23:0] cfg_wdata = '0;

	force_loop_board board = new();
	int  sent = 0;
	int  cycles = 0;
	bit  hold_req = 0;
	bit  hold_taken = 0;
	int  hold_left = 0;

	pi_force_loop_quintic_ref u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// watchdog: give up well beyond the slowest legal run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 4);
		if (r < 97) return $urandom_range(5, 20);
		return $urandom_range(30, 150);
	endfunction

	// receiver: random stalls, plus one long hold-off counted here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken = 1;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (arst_n) begin
			m_tready <= ($urandom_range(0, 99) < 35) ? 1'b0 : 1'b1;
		end
	end

	// note accepted beats and check results; both sample pre-edge values
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			board.note_beat(s_tuser, s_tdata[31:0], s_tdata[63:32]);
		if (m_tvalid && m_tready)
			board.check_result(m_tdata[31:0], m_tdata[55:32], m_tuser);
	end

	// offer one beat, hold it until taken, then maybe drop valid for a gap
	task automatic send_beat(logic mode, logic [31:0] el, logic [31:0] meas);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {meas, el};
		do @(posedge clk); while (!s_tready);
		sent++;
		gap = ($urandom_range(0, 9) < 3) ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, val);
	endtask

	// drop valid, drain owed results, then cover a trailing restart still in flight
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.owed.size() != 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_all(int ramp, int tgt, int ps, int ig, int per, int aw);
		write_reg(pfl_pkg::REG_RAMP, 24'(ramp));
		write_reg(pfl_pkg::REG_TARGET, 24'(tgt));
		write_reg(pfl_pkg::REG_PSCALE, 24'(ps));
		write_reg(pfl_pkg::REG_IGAIN, 24'(ig));
		write_reg(pfl_pkg::REG_PERIOD, 24'(per));
		write_reg(pfl_pkg::REG_AWEN, 24'(aw));
	endtask

	function int pick_reg(int lo, int hi);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return lo;
		if (r == 1) return hi;
		return $urandom_range(lo, hi);
	endfunction

	initial begin
		int ramp, n;
		logic [31:0] el, meas;
		longint off;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: reset settings, field extremes, ramp over, restart
		send_beat(MODE_TICK, 32'd0, 32'h8000_0000);
		send_beat(MODE_TICK, 32'd500, 32'h7FFF_FFFF);
		send_beat(MODE_TICK, 32'd999, 32'd0);
		send_beat(MODE_TICK, 32'd1000, 32'hFFFF_0000);
		send_beat(MODE_TICK, 32'hFFFF_FFFF, 32'h0001_0000);
		send_beat(pfl_pkg::MODE_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(MODE_TICK, 32'd250, 32'd0);
		settle();

		// pure P path, zero ramp: drive lands exactly on the clamp, then just past it
		write_all(0, 1023, 255, 0, 0, 1);
		write_reg(REG_SPARE_A, 24'hFFFFFF);
		write_reg(REG_SPARE_B, 24'h000001);
		send_beat(MODE_TICK, 32'd0, 32'((1023 - 70) <<< 16));
		send_beat(MODE_TICK, 32'd7, 32'((1023 + 70) <<< 16));
		send_beat(MODE_TICK, 32'd1, 32'(((1023 - 70) <<< 16) - 1));
		send_beat(MODE_TICK, 32'd2, 32'(((1023 + 70) <<< 16) + 1));
		settle();

		// top gains with anti-windup off, then on; shortest ramp from target 1023 down
		write_all(1, 0, 255, 65535, 65535, 0);
		send_beat(pfl_pkg::MODE_RESTART, 32'd0, 32'd0);
		send_beat(MODE_TICK, 32'd0, 32'h8000_0000);
		send_beat(MODE_TICK, 32'd0, 32'h8000_0000);
		send_beat(MODE_TICK, 32'd1, 32'h7FFF_FFFF);
		settle();
		write_reg(pfl_pkg::REG_AWEN, 24'd1);
		send_beat(MODE_TICK, 32'd0, 32'h7FFF_FFFF);
		send_beat(MODE_TICK, 32'd0, 32'h7FFF_FFFF);
		send_beat(MODE_TICK, 32'd5, 32'd0);
		settle();

		// random phases: new settings, then a restart and a ramp walk with noise
		while (sent < NUM_ITEMS) begin
			ramp = ($urandom_range(0, 9) == 0) ? 16777215 :
			       (($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215)
			                                     : $urandom_range(1, 4000));
			write_all(ramp, pick_reg(0, 1023), pick_reg(0, 255), pick_reg(0, 65535),
			          pick_reg(0, 65535), $urandom_range(0, 1));
			if (!hold_req && sent > NUM_ITEMS / 3)
				hold_req = 1;
			send_beat(pfl_pkg::MODE_RESTART, $urandom, $urandom);
			el = 0;
			n = $urandom_range(10, 40);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 9))
					0: send_beat(1'($urandom_range(0, 1)), $urandom, $urandom);
					1: send_beat(pfl_pkg::MODE_RESTART, $urandom, $urandom);
					default: begin
						// follow the reference with a small, sometimes large, error
						off = ($urandom_range(0, 3) == 0) ?
						      longint'($urandom_range(0, 1 << 26)) - (1 << 25) :
						      longint'($urandom_range(0, 1 << 18)) - (1 << 17);
						meas = 32'(board.cur_level + off);
						send_beat(MODE_TICK, el, meas);
						el = el + $urandom_range(0, ramp / 12 + 1);
						if ($urandom_range(0, 19) == 0)
							el = $urandom;
					end
				endcase
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fails == 0 && board.owed.size() == 0) begin
			$display("== PASS ==");
		end else begin
			if (board.owed.size() != 0)
				$error("%0d result beats never arrived", board.owed.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
